// File: rtl/fsim_pkg.sv
package fsim_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SEQ_W  = 64;
  localparam int unsigned QTY_W  = 32;
  localparam int unsigned FLAG_W = 3;
  localparam int unsigned MASK_W = 16;
  localparam int unsigned DCL_W  = 5;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] GAP_LIMIT_RST = 32'd16;

  localparam int unsigned FL_GAP_BIT     = 0;
  localparam int unsigned FL_CORRUPT_BIT = 1;
  localparam int unsigned FL_OOO_BIT     = 2;

  // divider: 48-bit dividend, one quotient bit per cycle
  localparam int unsigned DIV_N   = 48;
  localparam int unsigned DIV_CW  = 6;

  typedef enum logic [1:0] {
    ST_HEALTHY   = 2'd0,
    ST_DEGRADED  = 2'd1,
    ST_CORRUPTED = 2'd2,
    ST_LOCKED    = 2'd3
  } chan_status_t;

  typedef enum logic [1:0] {
    CONF_ZERO = 2'd0,
    CONF_HALF = 2'd1,
    CONF_FULL = 2'd2
  } conf_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_DIV  = 2'd1,
    FSM_OUT  = 2'd2
  } fsm_state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan_id;
    logic [SEQ_W-1:0]  seq_num;
    logic [QTY_W-1:0]  bid_qty;
    logic [QTY_W-1:0]  ask_qty;
    logic [QTY_W-1:0]  last_qty;
    logic [FLAG_W-1:0] flags;
    logic signed [31:0] vwap_delta;
    logic              kill;
    logic              hw_fault;
    logic [MASK_W-1:0] clone_mask;
    logic [DCL_W-1:0]  degraded_clones;
  } frame_t;

  typedef struct packed {
    logic [CHAN_W-1:0] result_channel;
    conf_t             confidence;
    logic [31:0]       energy_factor;
    logic signed [31:0] tick_acceleration;
    logic              feed_degraded;
    logic              freeze_required;
    logic              stress_escalation;
    chan_status_t      chan_state;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

// File: rtl/fsim_stream_if.sv
interface fsim_stream_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/fsim_ctrl.sv
module fsim_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fsim_pkg::dp_sts_t sts,
  output fsim_pkg::dp_cmd_t cmd
);
  import fsim_pkg::*;

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: if (in_valid) state_nxt = FSM_DIV;
      FSM_DIV:  if (sts.div_done) state_nxt = FSM_OUT;
      FSM_OUT:  if (!out_valid_r || out_ready) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    in_ready   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      FSM_DIV:  cmd.step = 1'b1;
      FSM_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// File: rtl/fsim_dp.sv
module fsim_dp #(
  parameter int unsigned NUM_CLONES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fsim_pkg::frame_t  in_frame,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  fsim_pkg::dp_cmd_t cmd,
  output fsim_pkg::dp_sts_t sts,
  output fsim_pkg::result_t res
);
  import fsim_pkg::*;

  localparam int unsigned MW = (NUM_CLONES < MASK_W) ? NUM_CLONES : MASK_W;

  logic [31:0]       gap_limit_r;
  logic [SEQ_W-1:0]  expected_seq_r;
  logic              seen_frame_r;
  logic [31:0]       gap_total_r;
  chan_status_t      status_r;
  frame_t            frm_r;
  result_t           res_r;

  // divider registers
  logic [DIV_N-1:0]  quo_r;
  logic [32:0]       rem_r;
  logic [32:0]       den_r;
  logic [DIV_CW-1:0] cnt_r;

  // frame decode
  logic [MW-1:0] cmask;
  logic lock, clone, ahead, behind;
  logic [SEQ_W-1:0] gaps;
  logic [31:0] room, gap_tot_nxt;
  assign cmask  = frm_r.clone_mask[MW-1:0];
  assign lock   = frm_r.kill | frm_r.hw_fault;
  assign clone  = (|cmask) | (|frm_r.degraded_clones);
  assign ahead  = seen_frame_r && (frm_r.seq_num > expected_seq_r);
  assign behind = seen_frame_r && (frm_r.seq_num < expected_seq_r);
  assign gaps   = frm_r.seq_num - expected_seq_r;
  assign room   = 32'hFFFF_FFFF - gap_total_r;
  assign gap_tot_nxt = (gaps >= {32'd0, room}) ? 32'hFFFF_FFFF
                                               : gap_total_r + gaps[31:0];

  // restoring division step
  logic [33:0] trial;
  assign trial = {rem_r, quo_r[DIV_N-1]} - {1'b0, den_r};
  assign sts.div_done = (cnt_r == DIV_CW'(DIV_N - 1));

  // result for the current frame
  logic [31:0] amp;
  chan_status_t st_mid;
  logic [31:0] gt_mid;
  result_t r;
  always_comb begin
    amp = (den_r == 33'd0) ? ONE_Q16
        : (|quo_r[DIV_N-1:32]) ? 32'hFFFF_FFFF : quo_r[31:0];
    st_mid = status_r;
    gt_mid = gap_total_r;
    r.result_channel    = frm_r.chan_id;
    r.confidence        = CONF_ZERO;
    r.energy_factor     = 32'd0;
    r.tick_acceleration = 32'sd0;
    r.feed_degraded     = 1'b1;
    r.freeze_required   = 1'b1;
    r.stress_escalation = 1'b1;
    if (lock) begin
      st_mid = ST_LOCKED;
    end else if (clone) begin
      st_mid = ST_DEGRADED;
    end else begin
      if (ahead) begin
        gt_mid = gap_tot_nxt;
        st_mid = ST_DEGRADED;
      end else if (behind) begin
        st_mid = ST_DEGRADED;
      end
      r.tick_acceleration = frm_r.vwap_delta;
      if (behind || (|frm_r.flags) || st_mid != ST_HEALTHY) begin
        if (gt_mid >= gap_limit_r || frm_r.flags[FL_CORRUPT_BIT]) begin
          st_mid = ST_CORRUPTED;
        end else begin
          r.stress_escalation = 1'b0;
          r.confidence    = behind ? CONF_ZERO : CONF_HALF;
          r.energy_factor = behind ? 32'd0 : amp;
        end
      end else begin
        r.confidence        = CONF_FULL;
        r.energy_factor     = amp;
        r.feed_degraded     = 1'b0;
        r.freeze_required   = 1'b0;
        r.stress_escalation = 1'b0;
      end
    end
    r.chan_state = st_mid;
  end

  assign res = res_r;

  // state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r    <= GAP_LIMIT_RST;
      expected_seq_r <= '0;
      seen_frame_r   <= 1'b0;
      gap_total_r    <= '0;
      status_r       <= ST_HEALTHY;
    end else begin
      if (cfg_we) gap_limit_r <= cfg_data;
      if (cmd.finish) begin
        status_r    <= st_mid;
        gap_total_r <= gt_mid;
        if (!lock && !clone && !behind) begin
          expected_seq_r <= frm_r.seq_num + 64'd1;
          seen_frame_r   <= 1'b1;
        end
      end
    end
  end

  // frame capture, divider and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frm_r <= in_frame;
      quo_r <= {in_frame.last_qty, 16'd0};
      rem_r <= '0;
      den_r <= {1'b0, in_frame.bid_qty} + {1'b0, in_frame.ask_qty};
      cnt_r <= '0;
    end else if (cmd.step) begin
      if (!trial[33]) begin
        rem_r <= trial[32:0];
        quo_r <= {quo_r[DIV_N-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], quo_r[DIV_N-1]};
        quo_r <= {quo_r[DIV_N-2:0], 1'b0};
      end
      cnt_r <= cnt_r + DIV_CW'(1);
    end
    if (cmd.finish) res_r <= r;
  end
endmodule

// File: rtl/feed_sequence_integrity_monitor_unit.sv
// Channel | Dir | Payload
// in_     | in  | frame: channel, sequence, sizes, flags, vwap, faults, clones
// out_    | out | result: channel, confidence, energy, tick, advisories, status
// cfg_    | in  | gap_limit write, no read-back
// Each frame is captured, goes through 48 steps of the bit-serial divider
// for last<<16 / (bid+ask), then the result register is written.
// Reset clears sequence state, status and gap total; gap_limit returns to 16.
// A stalled output holds the result; the next frame is still taken, and its
// result waits after the divide until the result register frees.
module feed_sequence_integrity_monitor_unit #(
  parameter int unsigned NUM_CLONES = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  fsim_stream_if.sink   in_if,
  fsim_stream_if.source out_if,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);
  import fsim_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t res;

  fsim_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .sts(sts), .cmd(cmd)
  );

  fsim_dp #(.NUM_CLONES(NUM_CLONES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_frame(frame_t'(in_if.data)),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .res(res)
  );

  assign out_if.data = res;
endmodule

// File: verif/fsim_frame_checker.sv
module fsim_frame_checker #(
  parameter int unsigned NUM_CLONES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  fsim_pkg::frame_t  in_frame,
  input  logic              out_valid,
  input  logic              out_ready,
  input  fsim_pkg::result_t out_result,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  output int                fail_count,
  output int                pending,
  output int                checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import fsim_pkg::*;

  // predictor state, mirrors the block after each frame
  logic [31:0]  gap_limit;
  logic [63:0]  exp_seq;
  logic         seen_frame;
  logic [31:0]  gap_total;
  chan_status_t status;

  result_t result_q[$];

  function automatic logic [31:0] energy_of(frame_t f);
    logic [32:0] depth;
    logic [47:0] quo;
    depth = {1'b0, f.bid_qty} + {1'b0, f.ask_qty};
    if (depth == '0) begin
      return ONE_Q16;
    end
    quo = {f.last_qty, 16'h0000} / {15'b0, depth};
    return (quo > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
  endfunction

  // advance the monitor state by one frame and return its result
  function automatic result_t predict_result(frame_t f);
    result_t     r;
    logic [63:0] clone_bits;
    logic [63:0] cmask;
    logic [63:0] gaps;
    logic [63:0] room;
    logic [31:0] amp;
    logic        ooo;
    clone_bits = (NUM_CLONES >= 64) ? '1 : ((64'd1 << NUM_CLONES) - 64'd1);
    cmask = {48'b0, f.clone_mask} & clone_bits;
    r.result_channel    = f.chan_id;
    r.confidence        = CONF_ZERO;
    r.energy_factor     = '0;
    r.tick_acceleration = '0;
    r.feed_degraded     = 1'b1;
    r.freeze_required   = 1'b1;
    r.stress_escalation = 1'b1;
    ooo = 1'b0;
    if (f.kill || f.hw_fault) begin
      status = ST_LOCKED;
    end else if (cmask != '0 || f.degraded_clones != '0) begin
      status = ST_DEGRADED;
    end else begin
      if (seen_frame) begin
        if (f.seq_num > exp_seq) begin
          gaps = f.seq_num - exp_seq;
          room = 64'hFFFF_FFFF - {32'b0, gap_total};
          gap_total = (gaps >= room) ? 32'hFFFF_FFFF : gap_total + gaps[31:0];
          status = ST_DEGRADED;
        end else if (f.seq_num < exp_seq) begin
          status = ST_DEGRADED;
          ooo = 1'b1;
        end
      end
      if (!ooo) begin
        exp_seq    = f.seq_num + 64'd1;
        seen_frame = 1'b1;
      end
      amp = energy_of(f);
      if (ooo || f.flags != '0 || status != ST_HEALTHY) begin
        if (gap_total >= gap_limit || f.flags[FL_CORRUPT_BIT]) begin
          status = ST_CORRUPTED;
        end else begin
          r.stress_escalation = 1'b0;
          r.confidence        = ooo ? CONF_ZERO : CONF_HALF;
          r.energy_factor     = ooo ? 32'h0 : amp;
        end
      end else begin
        r.confidence        = CONF_FULL;
        r.energy_factor     = amp;
        r.feed_degraded     = 1'b0;
        r.freeze_required   = 1'b0;
        r.stress_escalation = 1'b0;
      end
      r.tick_acceleration = f.vwap_delta;
    end
    r.chan_state = status;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // watch configuration, results and frames on each edge
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      gap_limit  = GAP_LIMIT_RST;
      exp_seq    = '0;
      seen_frame = 1'b0;
      gap_total  = '0;
      status     = ST_HEALTHY;
      fail_count = 0;
      checked    = 0;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        gap_limit = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result transfer with no frame outstanding");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          checked++;
          check_field("result_channel", 64'(want.result_channel),
                      64'(out_result.result_channel));
          check_field("confidence", 64'(want.confidence), 64'(out_result.confidence));
          check_field("energy_factor", 64'(want.energy_factor),
                      64'(out_result.energy_factor));
          check_field("tick_acceleration", 64'(want.tick_acceleration),
                      64'(out_result.tick_acceleration));
          check_field("feed_degraded", 64'(want.feed_degraded),
                      64'(out_result.feed_degraded));
          check_field("freeze_required", 64'(want.freeze_required),
                      64'(out_result.freeze_required));
          check_field("stress_escalation", 64'(want.stress_escalation),
                      64'(out_result.stress_escalation));
          check_field("chan_state", 64'(want.chan_state), 64'(out_result.chan_state));
        end
      end
      if (in_valid && in_ready) begin
        result_q.push_back(predict_result(in_frame));
      end
    end
    pending = result_q.size();
  end

endmodule

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fsim_pkg::*;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_FRAMES = 226;
  localparam int NUM_PHASES   = 5;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        quiet = 1'b0;
  int          stall = 0;
  int          cycles = 0;
  int          fail_count;
  int          pending;
  int          checked;
  int          settings = 0;

  // sequence number the block expects next, tracked on the stimulus side
  logic [63:0] next_seq = '0;
  logic        seq_started = 1'b0;

  fsim_stream_if #(.W($bits(frame_t)))  in_ch ();
  fsim_stream_if #(.W($bits(result_t))) out_ch ();

  feed_sequence_integrity_monitor_unit #(.NUM_CLONES(16)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  fsim_frame_checker #(.NUM_CLONES(16)) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_frame  (frame_t'(in_ch.data)),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_result(result_t'(out_ch.data)),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // stall the result side at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall <= 0;
    end else if (stall > 0) begin
      out_ch.ready <= 1'b0;
      stall <= stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && out_ch.valid && $urandom_range(0, 3) == 0) begin
        stall <= idle_len();
      end
    end
  end

  function automatic logic [31:0] rand_qty();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom_range(1, 20);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      3: return $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic frame_t clean_frame(logic [63:0] seq);
    frame_t f;
    f = '0;
    f.chan_id    = 8'($urandom);
    f.seq_num    = seq;
    f.bid_qty    = rand_qty();
    f.ask_qty    = rand_qty();
    f.last_qty   = rand_qty();
    f.vwap_delta = $urandom;
    return f;
  endfunction

  // mostly in-order frames with random content, the rest anomalies
  function automatic frame_t random_frame(bit wild);
    frame_t f;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 74)      f = clean_frame(next_seq);
    else if (r < 82) f = clean_frame(next_seq + $urandom_range(1, 5));
    else if (r < 88) f = clean_frame(next_seq - $urandom_range(1, 4));
    else if (wild)   f = clean_frame({$urandom, $urandom});
    else             f = clean_frame(next_seq);
    if ($urandom_range(0, 9) == 0) f.flags = 3'($urandom);
    if ($urandom_range(0, 39) == 0) f.kill = 1'b1;
    if ($urandom_range(0, 39) == 0) f.hw_fault = 1'b1;
    if ($urandom_range(0, 39) == 0) f.clone_mask = 16'($urandom);
    if ($urandom_range(0, 39) == 0) f.degraded_clones = 5'($urandom);
    return f;
  endfunction

  // hold the frame until it transfers, then idle
  task automatic send_frame(frame_t f);
    bit taken;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= f;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    if (!(f.kill || f.hw_fault || f.clone_mask != '0 ||
          f.degraded_clones != '0) &&
        !(seq_started && f.seq_num < next_seq)) begin
      next_seq    = f.seq_num + 64'd1;
      seq_started = 1'b1;
    end
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, drain every result, let the block settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap_limit(logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    settings++;
  endtask

  initial begin
    frame_t f;
    logic [31:0] limits [NUM_PHASES];
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    limits[0] = 32'hFFFF_FFFF;
    limits[1] = 32'h0;
    limits[2] = $urandom_range(200, 600);
    limits[3] = 32'hFFFF_FFFE;
    limits[4] = 32'hFFFF_FFFF;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // healthy frames (zero depth, saturation, widest depth, field extremes), then gap and out-of-order flags
    quiet = 1'b1;
    f = clean_frame(64'd5);
    f.bid_qty = '0; f.ask_qty = '0; f.last_qty = '1;
    send_frame(f);
    f = clean_frame(64'd6);
    f.bid_qty = 32'd1; f.ask_qty = '0; f.last_qty = '1;
    send_frame(f);
    f = clean_frame(64'd7);
    f.bid_qty = '1; f.ask_qty = '1; f.last_qty = '1;
    send_frame(f);
    f = clean_frame(64'd8);
    f.last_qty = '0; f.vwap_delta = 32'h8000_0000; f.chan_id = 8'hFF;
    send_frame(f);
    f = clean_frame(64'd9);
    f.vwap_delta = 32'h7FFF_FFFF; f.chan_id = 8'h00; f.flags = 3'b001;
    send_frame(f);
    f = clean_frame(64'd10);
    f.flags = 3'b100;
    send_frame(f);
    send_frame(clean_frame(64'd11));
    quiet = 1'b0;
    // gap, out-of-order, in-order on the degraded branch
    send_frame(clean_frame(64'd13));
    send_frame(clean_frame(64'd12));
    send_frame(clean_frame(64'd14));
    // clone and lock paths
    f = clean_frame(64'd15);
    f.clone_mask = 16'hFFFF;
    send_frame(f);
    f = clean_frame(64'd15);
    f.degraded_clones = 5'd31;
    send_frame(f);
    f = clean_frame(64'd15);
    f.hw_fault = 1'b1;
    send_frame(f);
    f = clean_frame(64'd15);
    f.kill = 1'b1;
    send_frame(f);
    // corrupted flag, then a jump past the reset gap limit
    f = clean_frame(64'd15);
    f.flags = 3'b010;
    send_frame(f);
    send_frame(clean_frame(64'd40));
    wait_drained();

    // random phases, one gap limit each, last one with wild jumps and wrap
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_gap_limit(limits[p]);
      quiet = (p == 2);
      if (p == NUM_PHASES - 1) begin
        send_frame(clean_frame(64'hFFFF_FFFF_FFFF_FFFF));
        send_frame(clean_frame(64'h0));
      end
      for (int i = 0; i < PHASE_FRAMES; i++) begin
        send_frame(random_frame(p == NUM_PHASES - 1));
      end
      wait_drained();
    end

    $display("Checked %0d results over %0d gap limit settings: healthy, gap, out-of-order,",
             checked, settings + 1);
    $display("lock, clone, corrupted, zero limit, saturation and sequence wrap cases.");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
